[rtl/oaht_pkg.sv]
// Shared types, codes and constants of the open-addressing hash table.
`default_nettype none

package oaht_pkg;

  // Fixed field widths
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned KEY_IN_W    = 64;
  localparam int unsigned HASH_W      = 64;
  localparam int unsigned ENTRY_W     = 12;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 4;

  // Parameter defaults
  localparam int unsigned DEF_MAX_SLOT_BITS = 12;
  localparam int unsigned DEF_KEY_WIDTH     = 64;

  // Probe sequence constants
  localparam int unsigned PERTURB_SHIFT   = 5;
  localparam int unsigned PROBE_EXTRA     = 13;
  localparam int unsigned MIN_SLOT_BITS   = 2;
  localparam int unsigned SLOT_BITS_RESET = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_BITS     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_PRESENT = CFG_INDEX_W'(1);

  // Item kinds; the remaining code is a no-op
  localparam logic [KIND_W-1:0] KIND_LOOKUP = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_INSERT = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_CLEAR  = KIND_W'(2);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_PROBE,
    ST_CLEAR,
    ST_RESPOND
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch_item;
    logic    start_probe;
    logic    step_probe;
    logic    write_slot;
    logic    clear_step;
    logic    clear_total;
    logic    res_load;
    logic    res_hit;
    status_e res_status;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              present;
    logic              full;
    logic              slot_empty;
    logic              slot_match;
    logic              bound_hit;
    logic              sweep_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/open_addressing_hash_table.sv]
// Top level of the open-addressing hash table with perturbed probing.
//
//  channel | handshake              | contents
//  --------+------------------------+------------------------------------------------
//  in      | in_valid_i/in_ready_o  | kind_i, key_word_i, key_hash_i, entry_index_i
//  out     | out_valid_o/out_ready_i| found_o, result_index_o, status_o, used_count_o
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i (0 slot_bits, 1 table_present), cfg_data_i
//
// For a lookup or insert the probe walk reads one slot per cycle from the slot memory
// port. A clear sweeps every memory row once; after reset the same sweep runs with
// in_ready_o low. Input is taken while a result word still waits; a finished item
// then waits until the output register is free. Configuration writes are always taken.
`default_nettype none

module open_addressing_hash_table #(
  parameter int unsigned MAX_SLOT_BITS = oaht_pkg::DEF_MAX_SLOT_BITS,
  parameter int unsigned KEY_WIDTH     = oaht_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [oaht_pkg::KIND_W-1:0]        kind_i,
  input  wire logic [oaht_pkg::KEY_IN_W-1:0]      key_word_i,
  input  wire logic signed [oaht_pkg::HASH_W-1:0] key_hash_i,
  input  wire logic [oaht_pkg::ENTRY_W-1:0]       entry_index_i,
  // Output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    found_o,
  output logic [oaht_pkg::ENTRY_W-1:0]            result_index_o,
  output logic [oaht_pkg::STATUS_W-1:0]           status_o,
  output logic [oaht_pkg::COUNT_W-1:0]            used_count_o,
  // Configuration channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [oaht_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [oaht_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import oaht_pkg::*;

  localparam int unsigned RAM_W = 1 + KEY_WIDTH + HASH_W + ENTRY_W;
  localparam int unsigned DEPTH = 1 << MAX_SLOT_BITS;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic                     ram_we;
  logic [MAX_SLOT_BITS-1:0] ram_waddr;
  logic [RAM_W-1:0]         ram_wdata;
  logic [MAX_SLOT_BITS-1:0] ram_raddr;
  logic [RAM_W-1:0]         ram_rdata;

  // Config writes never stall
  assign cfg_ready_o = 1'b1;

  oaht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  oaht_dp #(
    .MAX_SLOT_BITS (MAX_SLOT_BITS),
    .KEY_WIDTH     (KEY_WIDTH),
    .RAM_W         (RAM_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (kind_i),
    .key_word_i     (key_word_i),
    .key_hash_i     (key_hash_i),
    .entry_index_i  (entry_index_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .found_o        (found_o),
    .result_index_o (result_index_o),
    .status_o       (status_o),
    .used_count_o   (used_count_o)
  );

  // Slot memory: occupied flag, key, hash and entry index per row
  oaht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

[rtl/oaht_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module oaht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write when enabled; read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/oaht_ctrl.sv]
// Sequencer of the hash table: dispatch, probe walk, clear sweep and result handoff.
`default_nettype none

module oaht_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire oaht_pkg::dp_stat_t stat_i,
  output oaht_pkg::dp_cmd_t      cmd_o
);

  import oaht_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT_CLEAR: begin
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat_i.kind == KIND_LOOKUP) begin
          state_d = stat_i.present ? ST_PROBE : ST_RESPOND;
        end else if (stat_i.kind == KIND_INSERT) begin
          state_d = (stat_i.present && !stat_i.full) ? ST_PROBE : ST_RESPOND;
        end else if (stat_i.kind == KIND_CLEAR) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_RESPOND;
        end
      end
      ST_PROBE: begin
        if (stat_i.slot_empty || stat_i.bound_hit ||
            (stat_i.kind == KIND_LOOKUP && stat_i.slot_match)) begin
          state_d = ST_RESPOND;
        end
      end
      ST_CLEAR: begin
        if (stat_i.sweep_last) state_d = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = STATUS_OK;
    in_ready_o       = 1'b0;
    unique case (state_q)
      ST_INIT_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.latch_item = in_valid_i;
      end
      ST_DISPATCH: begin
        if (stat_i.kind == KIND_LOOKUP || stat_i.kind == KIND_INSERT) begin
          if (!stat_i.present) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = STATUS_ABSENT;
          end else if (stat_i.kind == KIND_INSERT && stat_i.full) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = STATUS_FULL;
          end else begin
            cmd_o.start_probe = 1'b1;
          end
        end else if (stat_i.kind != KIND_CLEAR) begin
          cmd_o.res_load = 1'b1;
        end
      end
      ST_PROBE: begin
        if (stat_i.slot_empty) begin
          cmd_o.write_slot = (stat_i.kind == KIND_INSERT);
          cmd_o.res_load   = 1'b1;
        end else if (stat_i.kind == KIND_LOOKUP && stat_i.slot_match) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = 1'b1;
        end else if (stat_i.bound_hit) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = (stat_i.kind == KIND_INSERT) ? STATUS_FULL : STATUS_OK;
        end else begin
          cmd_o.step_probe = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.clear_total = 1'b1;
          cmd_o.res_load    = 1'b1;
        end
      end
      ST_RESPOND: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  // Hold the result word until it is taken
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/oaht_dp.sv]
// Datapath of the hash table: config registers, probe address, compare, counters, result.
`default_nettype none

module oaht_dp #(
  parameter int unsigned MAX_SLOT_BITS = oaht_pkg::DEF_MAX_SLOT_BITS,
  parameter int unsigned KEY_WIDTH     = oaht_pkg::DEF_KEY_WIDTH,
  parameter int unsigned RAM_W         = 1 + KEY_WIDTH + oaht_pkg::HASH_W + oaht_pkg::ENTRY_W
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration writes
  input  wire logic                               cfg_valid_i,
  input  wire logic [oaht_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [oaht_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input word
  input  wire logic [oaht_pkg::KIND_W-1:0]        kind_i,
  input  wire logic [oaht_pkg::KEY_IN_W-1:0]      key_word_i,
  input  wire logic signed [oaht_pkg::HASH_W-1:0] key_hash_i,
  input  wire logic [oaht_pkg::ENTRY_W-1:0]       entry_index_i,
  // Controller link
  input  wire oaht_pkg::dp_cmd_t                  cmd_i,
  output oaht_pkg::dp_stat_t                      stat_o,
  // Slot memory
  output logic                                    ram_we_o,
  output logic [MAX_SLOT_BITS-1:0]                ram_waddr_o,
  output logic [RAM_W-1:0]                        ram_wdata_o,
  output logic [MAX_SLOT_BITS-1:0]                ram_raddr_o,
  input  wire logic [RAM_W-1:0]                   ram_rdata_i,
  // Result word
  output logic                                    found_o,
  output logic [oaht_pkg::ENTRY_W-1:0]            result_index_o,
  output logic [oaht_pkg::STATUS_W-1:0]           status_o,
  output logic [oaht_pkg::COUNT_W-1:0]            used_count_o
);

  import oaht_pkg::*;

  localparam int unsigned SLOT_W = MAX_SLOT_BITS;
  localparam int unsigned TOT_W  = MAX_SLOT_BITS + 1;
  localparam int unsigned CNT_W  = MAX_SLOT_BITS + 5;
  localparam int unsigned EB_W   = $clog2(MAX_SLOT_BITS + 1);
  localparam logic [SLOT_W-1:0] SLOT_ONES = {SLOT_W{1'b1}};

  // Config registers
  logic [CFG_DATA_W-1:0] slot_bits_q;
  logic                  present_q;

  // Latched item
  logic [KIND_W-1:0]    kind_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [HASH_W-1:0]    hash_q;
  logic [ENTRY_W-1:0]   entry_q;

  // Walk and bookkeeping
  logic [SLOT_W-1:0] slot_q, slot_d, slot_next;
  logic [HASH_W-1:0] perturb_q, perturb_next;
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] sweep_q;
  logic [TOT_W-1:0]  total_q;

  // Result staging and output word
  logic               res_found_q;
  logic [ENTRY_W-1:0] res_index_q;
  status_e            res_status_q;

  logic [EB_W-1:0]    eff_bits;
  logic [SLOT_W-1:0]  mask;
  logic [TOT_W-1:0]   count;
  logic [TOT_W:0]     total_inc;

  logic                 rd_occ;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [HASH_W-1:0]    rd_hash;
  logic [ENTRY_W-1:0]   rd_entry;

  // Saturate the slot bits to the supported range
  always_comb begin
    if (int'(slot_bits_q) < MIN_SLOT_BITS) begin
      eff_bits = EB_W'(MIN_SLOT_BITS);
    end else if (int'(slot_bits_q) > MAX_SLOT_BITS) begin
      eff_bits = EB_W'(MAX_SLOT_BITS);
    end else begin
      eff_bits = EB_W'(slot_bits_q);
    end
  end

  assign mask      = ~(SLOT_ONES << eff_bits);
  assign count     = TOT_W'(1) << eff_bits;
  assign total_inc = (TOT_W + 1)'(total_q) + (TOT_W + 1)'(1);

  // Unpack the slot read back from memory
  assign rd_occ   = ram_rdata_i[RAM_W-1];
  assign rd_key   = ram_rdata_i[RAM_W-2 -: KEY_WIDTH];
  assign rd_hash  = ram_rdata_i[HASH_W+ENTRY_W-1 -: HASH_W];
  assign rd_entry = ram_rdata_i[ENTRY_W-1:0];

  // Next probe position: perturb shifts first, then feeds the step
  assign perturb_next = perturb_q >> PERTURB_SHIFT;
  assign slot_next    = ((slot_q << 2) + slot_q + SLOT_W'(1) + perturb_next[SLOT_W-1:0]) & mask;

  always_comb begin
    if (cmd_i.start_probe) begin
      slot_d = hash_q[SLOT_W-1:0] & mask;
    end else if (cmd_i.step_probe) begin
      slot_d = slot_next;
    end else begin
      slot_d = slot_q;
    end
  end

  // Status toward the controller
  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.present    = present_q;
    stat_o.full       = total_inc >= (TOT_W + 1)'(count);
    stat_o.slot_empty = !rd_occ;
    stat_o.slot_match = (rd_hash == hash_q) && (rd_key == key_q);
    stat_o.bound_hit  = cnt_q == (CNT_W'(count) + CNT_W'(PROBE_EXTRA - 1));
    stat_o.sweep_last = sweep_q == SLOT_ONES;
  end

  // Memory ports: read follows the probe, write inserts or sweeps
  assign ram_raddr_o = slot_d;
  assign ram_we_o    = cmd_i.write_slot || cmd_i.clear_step;
  assign ram_waddr_o = cmd_i.clear_step ? sweep_q : slot_q;
  assign ram_wdata_o = cmd_i.clear_step ? '0 : {1'b1, key_q, hash_q, entry_q};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bits_q <= CFG_DATA_W'(SLOT_BITS_RESET);
      present_q   <= 1'b0;
      sweep_q     <= '0;
      total_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_SLOT_BITS) begin
        slot_bits_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_TABLE_PRESENT) begin
        present_q <= cfg_data_i[0];
      end
      if (cmd_i.clear_step) begin
        sweep_q <= sweep_q + SLOT_W'(1);
      end
      if (cmd_i.clear_total) begin
        total_q <= '0;
      end else if (cmd_i.write_slot) begin
        total_q <= total_q + TOT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      kind_q  <= kind_i;
      key_q   <= key_word_i[KEY_WIDTH-1:0];
      hash_q  <= $unsigned(key_hash_i);
      entry_q <= entry_index_i;
    end
    slot_q <= slot_d;
    if (cmd_i.start_probe) begin
      perturb_q <= hash_q;
      cnt_q     <= '0;
    end else if (cmd_i.step_probe) begin
      perturb_q <= perturb_next;
      cnt_q     <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.res_load) begin
      res_found_q  <= cmd_i.res_hit;
      res_index_q  <= cmd_i.res_hit ? rd_entry : '0;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      found_o        <= res_found_q;
      result_index_o <= res_index_q;
      status_o       <= res_status_q;
      used_count_o   <= COUNT_W'(total_q);
    end
  end

endmodule

`default_nettype wire

[bench/tb_open_addressing_hash_table.sv]
// Self-checking bench for the open-addressing hash table: drives words, predicts and checks replies.
`timescale 1ns / 100ps

module tb_open_addressing_hash_table;
  import oaht_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NOP = KIND_W'(3);
  localparam int unsigned SLOT_CAP = 1 << DEF_MAX_SLOT_BITS;
  localparam int unsigned OP_TARGET = 1200;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [KEY_IN_W-1:0] key;
    logic [HASH_W-1:0]   hash;
    logic [ENTRY_W-1:0]  entry;
  } table_op_t;

  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] index;
    status_e            status;
    logic [COUNT_W-1:0] used;
  } table_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [KIND_W-1:0] kind_i = '0;
  logic [KEY_IN_W-1:0] key_word_i = '0;
  logic signed [HASH_W-1:0] key_hash_i = '0;
  logic [ENTRY_W-1:0] entry_index_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_ready_o, out_valid_o, found_o, cfg_ready_o;
  logic [ENTRY_W-1:0] result_index_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0] used_count_o;

  // Words waiting to be sent and replies waiting to arrive
  table_op_t op_queue[$];
  table_reply_t reply_queue[$];
  int op_sent = 0;
  int op_taken = 0;
  int replies_seen = 0;
  int mismatch_count = 0;
  bit steady_run = 1'b0;

  // Register copies, owned by the stimulus process
  logic [CFG_DATA_W-1:0] cfg_slot_bits = CFG_DATA_W'(SLOT_BITS_RESET);
  logic cfg_present = 1'b0;

  // Predicted table contents, owned by the monitor
  logic [KEY_IN_W-1:0] slot_key[SLOT_CAP];
  logic [HASH_W-1:0] slot_hash[SLOT_CAP];
  logic [ENTRY_W-1:0] slot_entry[SLOT_CAP];
  bit slot_full[SLOT_CAP];
  int unsigned used_slots = 0;

  // Known keys for building lookups that hit
  logic [KEY_IN_W-1:0] known_key[$];
  logic [HASH_W-1:0] known_hash[$];

  open_addressing_hash_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .key_word_i    (key_word_i),
    .key_hash_i    (key_hash_i),
    .entry_index_i (entry_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .result_index_o(result_index_o),
    .status_o      (status_o),
    .used_count_o  (used_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic table_op_t make_op(input logic [KIND_W-1:0] kind,
                                        input logic [KEY_IN_W-1:0] key,
                                        input logic [HASH_W-1:0] hash,
                                        input logic [ENTRY_W-1:0] entry);
    table_op_t op;
    op.kind = kind;
    op.key = key;
    op.hash = hash;
    op.entry = entry;
    return op;
  endfunction

  // Clamp the slot-bits register to the supported range
  function automatic int unsigned active_bits();
    if (cfg_slot_bits < MIN_SLOT_BITS) return MIN_SLOT_BITS;
    if (cfg_slot_bits > DEF_MAX_SLOT_BITS) return DEF_MAX_SLOT_BITS;
    return cfg_slot_bits;
  endfunction

  // Walk the perturbed probe sequence; stop at an empty slot or, if asked, a match
  function automatic bit probe_walk(input logic [KEY_IN_W-1:0] key,
                                    input logic [HASH_W-1:0] hash,
                                    input bit want_match, output int unsigned pos);
    int unsigned count;
    int unsigned s;
    logic [63:0] mask, perturb, slot;
    count = 1 << active_bits();
    mask = 64'(count - 1);
    perturb = hash;
    slot = hash & mask;
    pos = 0;
    for (int unsigned i = 0; i < PROBE_EXTRA + count; i++) begin
      s = int'(slot[DEF_MAX_SLOT_BITS-1:0]);
      if (!slot_full[s]) begin
        pos = s;
        return 1'b1;
      end
      if (want_match && slot_hash[s] == hash && slot_key[s] == key) begin
        pos = s;
        return 1'b1;
      end
      perturb = perturb >> PERTURB_SHIFT;
      slot = (64'd5 * slot + 64'd1 + perturb) & mask;
    end
    return 1'b0;
  endfunction

  // Apply one word to the predicted table and return its reply
  function automatic table_reply_t table_apply(input table_op_t op);
    table_reply_t r;
    int unsigned pos;
    int unsigned count;
    r = '{found: 1'b0, index: '0, status: STATUS_OK, used: '0};
    count = 1 << active_bits();
    case (op.kind)
      KIND_LOOKUP: begin
        if (!cfg_present) begin
          r.status = STATUS_ABSENT;
        end else if (probe_walk(op.key, op.hash, 1'b1, pos) && slot_full[pos]) begin
          r.found = 1'b1;
          r.index = slot_entry[pos];
        end
      end
      KIND_INSERT: begin
        if (!cfg_present) begin
          r.status = STATUS_ABSENT;
        end else if (used_slots + 1 >= count) begin
          r.status = STATUS_FULL;
        end else if (probe_walk(op.key, op.hash, 1'b0, pos)) begin
          slot_key[pos] = op.key;
          slot_hash[pos] = op.hash;
          slot_entry[pos] = op.entry;
          slot_full[pos] = 1'b1;
          used_slots++;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      KIND_CLEAR: begin
        foreach (slot_full[i]) slot_full[i] = 1'b0;
        used_slots = 0;
      end
      default: begin
      end
    endcase
    r.used = COUNT_W'(used_slots);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s on reply %0d: got %0h, expected %0h",
             what, replies_seen, got, want);
    mismatch_count++;
  endtask

  // Driver: launch words and set the reply-side backpressure
  always @(negedge clk_i) begin
    table_op_t op;
    out_ready_i <= steady_run || ($urandom_range(99) >= 14);
    if (rst_ni && (!in_valid_i || op_taken == op_sent)) begin
      if (op_queue.size() != 0 && (steady_run || $urandom_range(99) >= 14)) begin
        op = op_queue.pop_front();
        kind_i <= op.kind;
        key_word_i <= op.key;
        key_hash_i <= op.hash;
        entry_index_i <= op.entry;
        in_valid_i <= 1'b1;
        op_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each reply word, then predict for each accepted word
  always @(posedge clk_i) begin
    table_reply_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{found: found_o, index: result_index_o, status: status_e'(status_o),
                used: used_count_o};
        if (reply_queue.size() == 0) begin
          report_mismatch("unexpected reply, used_count", 64'(got.used), 64'd0);
        end else begin
          want = reply_queue.pop_front();
          if (got.found !== want.found)
            report_mismatch("found", 64'(got.found), 64'(want.found));
          if (got.index !== want.index)
            report_mismatch("result_index", 64'(got.index), 64'(want.index));
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.used !== want.used)
            report_mismatch("used_count", 64'(got.used), 64'(want.used));
        end
        replies_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        reply_queue.push_back(table_apply(make_op(kind_i, key_word_i, key_hash_i,
                                                  entry_index_i)));
        op_taken++;
      end
    end
  end

  // Write one register while the block is idle and track it
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_index_i <= index;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_SLOT_BITS: cfg_slot_bits = data;
      CFG_TABLE_PRESENT: cfg_present = data[0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold off until every queued word is sent and every reply has arrived
  task automatic wait_idle();
    while (op_queue.size() != 0 || op_sent != op_taken || reply_queue.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic logic [KEY_IN_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return 64'($urandom_range(7));
      1: return ~64'($urandom_range(7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [HASH_W-1:0] pick_hash();
    case ($urandom_range(5))
      0: return 64'($urandom_range(31));
      1: return {$urandom, 27'd0, 5'($urandom_range(31))};
      2: return {32'hFFFF_FFFF, $urandom};
      3: return {1'b1, 63'd0} | 64'($urandom_range(3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    logic [KEY_IN_W-1:0] key;
    logic [HASH_W-1:0] hash;
    logic [CFG_DATA_W-1:0] bits;
    int r, j, n, phase, random_ops;
    phase = 0;
    random_ops = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // No table yet: lookup and insert report absence, clear still works
    op_queue.push_back(make_op(KIND_LOOKUP, 64'd5, 64'd0, 12'd0));
    op_queue.push_back(make_op(KIND_INSERT, 64'd5, 64'd0, 12'hFFF));
    op_queue.push_back(make_op(KIND_CLEAR, 64'd0, 64'd0, 12'd0));
    op_queue.push_back(make_op(KIND_NOP, 64'd0, 64'd0, 12'd0));
    wait_idle();
    write_reg(CFG_TABLE_PRESENT, 4'd1);

    // Four slots: fill to the refusal point, hits, misses, duplicate keys
    op_queue.push_back(make_op(KIND_INSERT, 64'd0, 64'd0, 12'd0));
    op_queue.push_back(make_op(KIND_INSERT, '1, {1'b1, 63'd0}, 12'hFFF));
    op_queue.push_back(make_op(KIND_INSERT, 64'd0, 64'd0, 12'd7));
    op_queue.push_back(make_op(KIND_INSERT, 64'd9, {1'b0, {63{1'b1}}}, 12'd1));
    op_queue.push_back(make_op(KIND_LOOKUP, '1, {1'b1, 63'd0}, 12'd0));
    op_queue.push_back(make_op(KIND_LOOKUP, 64'd0, 64'd0, 12'd0));
    op_queue.push_back(make_op(KIND_LOOKUP, 64'd0, '1, 12'd0));
    op_queue.push_back(make_op(KIND_LOOKUP, 64'd1, 64'd0, 12'd0));
    op_queue.push_back(make_op(KIND_NOP, '1, '1, 12'hFFF));
    wait_idle();

    // Slot bits above the top saturate to the largest table
    write_reg(CFG_SLOT_BITS, 4'd15);
    op_queue.push_back(make_op(KIND_INSERT, 64'd3, '1, 12'd2));
    op_queue.push_back(make_op(KIND_LOOKUP, 64'd0, 64'd0, 12'd0));
    wait_idle();

    // Fill the low slots at sixteen slots, then shrink to force a full walk
    write_reg(CFG_SLOT_BITS, 4'd4);
    op_queue.push_back(make_op(KIND_CLEAR, 64'd0, 64'd0, 12'd0));
    for (int k = 0; k < 4; k++)
      op_queue.push_back(make_op(KIND_INSERT, 64'(10 + k), 64'(k), 12'(100 + k)));
    op_queue.push_back(make_op(KIND_INSERT, 64'd14, 64'd16, 12'd104));
    wait_idle();
    write_reg(CFG_SLOT_BITS, 4'd0);
    op_queue.push_back(make_op(KIND_LOOKUP, 64'd99, 64'd0, 12'd0));
    op_queue.push_back(make_op(KIND_LOOKUP, 64'd13, 64'd3, 12'd0));
    op_queue.push_back(make_op(KIND_INSERT, 64'd20, 64'd5, 12'd5));
    op_queue.push_back(make_op(KIND_CLEAR, 64'd0, 64'd0, 12'd0));
    wait_idle();

    // Random phases: new table size per phase, mostly insert-then-lookup traffic
    while (random_ops < OP_TARGET) begin
      phase++;
      steady_run = (phase == 4);
      r = $urandom_range(99);
      if (r < 70) bits = 4'($urandom_range(6, 2));
      else if (r < 85) bits = 4'($urandom_range(11, 7));
      else if (r < 93) bits = 4'($urandom_range(1, 0));
      else bits = 4'($urandom_range(15, 12));
      write_reg(CFG_SLOT_BITS, bits);
      write_reg(CFG_TABLE_PRESENT, ($urandom_range(99) < 92) ? 4'd1 : 4'd0);
      if ($urandom_range(1) == 0) begin
        op_queue.push_back(make_op(KIND_CLEAR, {$urandom, $urandom}, pick_hash(),
                                   12'($urandom)));
        known_key.delete();
        known_hash.delete();
        random_ops++;
      end
      n = steady_run ? 120 : $urandom_range(60, 20);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(99);
        if (r < 40) begin
          // insert, sometimes a stored key again
          if (known_key.size() != 0 && r < 10) begin
            j = $urandom_range(known_key.size() - 1);
            key = known_key[j];
            hash = ($urandom_range(1) == 1) ? known_hash[j] : pick_hash();
          end else begin
            key = pick_key();
            hash = pick_hash();
          end
          op_queue.push_back(make_op(KIND_INSERT, key, hash, 12'($urandom)));
          known_key.push_back(key);
          known_hash.push_back(hash);
          random_ops++;
        end else if (r < 80 && known_key.size() != 0) begin
          // lookup a stored key, now and then under another hash
          j = $urandom_range(known_key.size() - 1);
          key = known_key[j];
          hash = (r < 74) ? known_hash[j] : pick_hash();
          op_queue.push_back(make_op(KIND_LOOKUP, key, hash, 12'($urandom)));
          random_ops++;
        end else if (r < 94) begin
          op_queue.push_back(make_op(KIND_LOOKUP, pick_key(), pick_hash(), 12'($urandom)));
          random_ops++;
        end else if (r < 98) begin
          op_queue.push_back(make_op(KIND_NOP, {$urandom, $urandom}, {$urandom, $urandom},
                                     12'($urandom)));
        end else begin
          op_queue.push_back(make_op(KIND_CLEAR, pick_key(), pick_hash(), 12'($urandom)));
          known_key.delete();
          known_hash.delete();
          random_ops++;
        end
      end
      wait_idle();
    end
    steady_run = 1'b0;

    // Let any stray reply word show up before the verdict
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && reply_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #400ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/oaht_pkg.sv
rtl/oaht_ram.sv
rtl/oaht_ctrl.sv
rtl/oaht_dp.sv
rtl/open_addressing_hash_table.sv
bench/tb_open_addressing_hash_table.sv
